@@ src/double_round_to_int_width_core_macros.svh @@
// assertion macros for the rounding core checker
`ifndef DOUBLE_ROUND_TO_INT_WIDTH_CORE_MACROS_SVH
`define DOUBLE_ROUND_TO_INT_WIDTH_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define DRI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define DRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/dri_pkg.sv @@
// ----------------------------------------------------------------------------
// dri_pkg
// types and constants shared by the binary64 round-to-integer core
// ----------------------------------------------------------------------------
package dri_pkg;

    localparam int unsigned MantBits = 52;
    localparam int unsigned ExpBits  = 11;
    localparam logic [10:0] ExpAll   = 11'h7ff;
    localparam logic [10:0] ExpBias  = 11'h3ff;
    localparam logic [11:0] MinBase  = 12'hbfe;
    localparam logic [63:0] QuietNan = 64'h7FF8000000000000;
    localparam logic [63:0] PosOne   = 64'h3FF0000000000000;
    localparam logic [63:0] NegOne   = 64'hBFF0000000000000;

    // rounding mode codes
    localparam logic [2:0] RM_NEAR_EVEN = 3'd0;
    localparam logic [2:0] RM_NEAR_AWAY = 3'd1;
    localparam logic [2:0] RM_ZERO      = 3'd2;
    localparam logic [2:0] RM_UP        = 3'd3;
    localparam logic [2:0] RM_DOWN      = 3'd4;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [2:0]  rounding_mode;
        logic [6:0]  int_width;
    } t_in;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        invalid;
    } t_out;

endpackage

@@ src/dri_round.sv @@
// ----------------------------------------------------------------------------
// dri_round
// three-stage pipeline: decode and mask, add and clear, range check
// ----------------------------------------------------------------------------
module dri_round
    import dri_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_item
);

    // stage 1: decode, pick mode, build increment and mask
    logic [10:0] s1_be;
    logic [2:0]  s1_mode;
    logic        s1_neg;
    logic [5:0]  s1_sh;
    logic [63:0] s1_fm, s1_inc, s1_small;
    logic        s1_is_small, s1_bad;

    always_comb begin
        s1_be   = i_item.value_bits[62:52];
        s1_neg  = i_item.value_bits[63];
        s1_mode = (i_item.rounding_mode > RM_DOWN) ? RM_ZERO : i_item.rounding_mode;
        s1_bad  = (s1_be == ExpAll) || (i_item.int_width == 7'd0);
        s1_is_small = s1_be < ExpBias;
        s1_sh   = 6'(11'd52 - (s1_be - ExpBias));
        s1_fm   = 64'd0;
        s1_inc  = 64'd0;
        if (!s1_is_small && s1_be < ExpBias + 11'd52) begin
            s1_fm = (64'd1 << s1_sh) - 64'd1;
            case (s1_mode)
                RM_NEAR_EVEN: s1_inc = (s1_fm >> 1)
                    + 64'(i_item.value_bits[s1_sh]);
                RM_NEAR_AWAY: s1_inc = (s1_fm >> 1) + 64'd1;
                RM_UP:        s1_inc = s1_neg ? 64'd0 : s1_fm;
                RM_DOWN:      s1_inc = s1_neg ? s1_fm : 64'd0;
                default:      s1_inc = 64'd0;
            endcase
        end
        // small magnitude result
        s1_small = {s1_neg, 63'd0};
        if (i_item.value_bits[62:0] == 63'd0) begin
            s1_small = i_item.value_bits;
        end else begin
            case (s1_mode)
                RM_NEAR_EVEN: if (s1_be == ExpBias - 11'd1 && i_item.value_bits[51:0] != 52'd0)
                    s1_small = s1_neg ? NegOne : PosOne;
                RM_NEAR_AWAY: if (s1_be == ExpBias - 11'd1)
                    s1_small = s1_neg ? NegOne : PosOne;
                RM_UP:        if (!s1_neg) s1_small = PosOne;
                RM_DOWN:      if (s1_neg) s1_small = NegOne;
                default:      s1_small = {s1_neg, 63'd0};
            endcase
        end
    end

    logic        r_v1, r_v2, r_v3;
    logic [63:0] r_x1, r_inc1, r_fm1, r_small1, r_r2;
    logic        r_sm1, r_bad1, r_bad2, r_bad3;
    logic [6:0]  r_w1, r_w2;
    logic [63:0] r_r3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 2: add increment and clear fraction, or take the small-magnitude result
    logic [63:0] s2_r;
    assign s2_r = r_sm1 ? r_small1 : ((r_x1 + r_inc1) & ~r_fm1);

    // stage 3: range check against the signed width
    logic [10:0] s3_re, s3_e;
    logic [11:0] s3_min;
    logic        s3_bad;
    always_comb begin
        s3_re  = r_r2[62:52];
        s3_e   = s3_re - ExpBias;
        s3_min = MinBase + {5'd0, r_w2};
        s3_bad = r_bad2;
        if (s3_re >= ExpBias) begin
            if ({1'b0, s3_e} > {5'd0, r_w2} - 12'd1 ||
                ({1'b0, s3_e} == {5'd0, r_w2} - 12'd1 && r_r2 != {s3_min, 52'd0}))
                s3_bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1     <= i_item.value_bits;
        r_inc1   <= s1_inc;
        r_fm1    <= s1_fm;
        r_small1 <= s1_small;
        r_sm1    <= s1_is_small;
        r_bad1   <= s1_bad;
        r_w1     <= i_item.int_width;
        r_r2     <= s2_r;
        r_bad2   <= r_bad1;
        r_w2     <= r_w1;
        r_r3     <= s3_bad ? QuietNan : r_r2;
        r_bad3   <= s3_bad;
    end

    assign o_valid = r_v3;
    assign o_item  = '{result_bits: r_r3, invalid: r_bad3};

endmodule

@@ src/double_round_to_int_width_core.sv @@
// ----------------------------------------------------------------------------
// double_round_to_int_width_core
// rounds a binary64 to an integral value and checks it against a signed width
// ----------------------------------------------------------------------------
// One operand per cycle; busy stays low. Each result passes from its start transfer
// through a three-stage pipeline (decode, add, range check) and leaves
// marked by a one-cycle o_done strobe; the receiver cannot stall it.
module double_round_to_int_width_core
    import dri_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_done,
    output t_out o_item
);

    // pipeline never stalls
    assign busy = 1'b0;

    dri_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (o_done),
        .o_item  (o_item)
    );

endmodule

@@ src/dri_checker.sv @@
// ----------------------------------------------------------------------------
// dri_checker
// port-level checks on the rounding core
// ----------------------------------------------------------------------------
`include "double_round_to_int_width_core_macros.svh"

module dri_checker
    import dri_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_out o_item
);

    // start transfer taken at this edge
    logic xfer;
    assign xfer = start && !busy;

    // a strobe follows every start transfer taken outside reset
    `DRI_ASSERT_IMP(a_latency, i_clk, i_rst_n, $past(xfer, 3) && $past(i_rst_n, 3), o_done)
    // invalid results carry the quiet nan
    `DRI_ASSERT_IMP(a_nan, i_clk, i_rst_n, o_done && o_item.invalid, o_item.result_bits == QuietNan)
    // no strobe without a start
    `DRI_ASSERT_IMP(a_nospur, i_clk, i_rst_n, o_done && $past(i_rst_n, 3), $past(start, 3))

endmodule

bind double_round_to_int_width_core dri_checker u_dri_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_item  (o_item)
);

@@ tb/sv/tb_double_round_to_int_width_core.sv @@
// ----------------------------------------------------------------------------
// tb_double_round_to_int_width_core
// self-checking bench for the binary64 round-to-integer core: directed corner
// operands, then random operands biased toward the rounding boundaries; each
// result is compared field by field to a typed-in value or a local predictor
// ----------------------------------------------------------------------------
module tb_double_round_to_int_width_core;
    import dri_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_done;
    t_out o_item;

    t_out rounded_q[$];
    int   err_cnt;
    int   idle_pct;

    typedef struct {
        t_in  op;
        bit   has_exp;
        t_out exp;
    } t_row;

    double_round_to_int_width_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_item  (o_item)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // rounds the operand to an integral pattern
    function automatic logic [63:0] round_integral(logic [63:0] x, logic [2:0] rm_in);
        logic        neg;
        logic [10:0] be;
        logic [63:0] one;
        logic [63:0] zero;
        logic [63:0] fm;
        logic [2:0]  rm;
        int unsigned sh;
        neg  = x[63];
        be   = x[62:52];
        rm   = (rm_in > RM_DOWN) ? RM_ZERO : rm_in;
        one  = neg ? NegOne : PosOne;
        zero = {neg, 63'd0};
        if (be < ExpBias) begin
            if (x[62:0] == 63'd0) return x;
            case (rm)
                RM_NEAR_EVEN: return (be == ExpBias - 1 && x[51:0] != 0) ? one : zero;
                RM_NEAR_AWAY: return (be == ExpBias - 1) ? one : zero;
                RM_UP:        return neg ? zero : one;
                RM_DOWN:      return neg ? one : zero;
                default:      return zero;
            endcase
        end
        if (be < ExpBias + MantBits) begin
            sh = MantBits - (be - ExpBias);
            fm = (64'd1 << sh) - 64'd1;
            case (rm)
                RM_NEAR_EVEN: x = x + (fm >> 1) + ((x >> sh) & 64'd1);
                RM_NEAR_AWAY: x = x + (fm >> 1) + 64'd1;
                RM_UP:        if (!neg) x = x + fm;
                RM_DOWN:      if (neg) x = x + fm;
                default:      ;
            endcase
            return x & ~fm;
        end
        return x;
    endfunction

    // full prediction including range check
    function automatic t_out predict_round(t_in op);
        t_out        r;
        logic [63:0] v;
        logic [63:0] min_pat;
        int unsigned e;
        int unsigned w;
        bit          bad;
        w   = op.int_width;
        bad = 0;
        v   = 64'd0;
        if (op.value_bits[62:52] == ExpAll || w == 0) begin
            bad = 1;
        end else begin
            v = round_integral(op.value_bits, op.rounding_mode);
            if (v[62:52] >= ExpBias) begin
                e       = v[62:52] - ExpBias;
                min_pat = {52'd0, MinBase} + 64'(w);
                min_pat = min_pat << MantBits;
                if (e > w - 1 || (e == w - 1 && v != min_pat)) bad = 1;
            end
        end
        r.result_bits = bad ? QuietNan : v;
        r.invalid     = bad;
        return r;
    endfunction

    // random operand biased toward integers and rounding edges
    function automatic t_in rand_op();
        t_in op;
        int  k;
        k = $urandom_range(0, 9);
        op.value_bits = {$urandom, $urandom};
        if (k < 7) begin
            op.value_bits[62:52] = 11'(ExpBias - 3 + $urandom_range(0, 70));
            if (k < 2) op.value_bits[40:0] = (k == 0) ? 41'd0 : {1'b1, 40'd0};
        end else if (k == 7) begin
            op.value_bits[62:52] = ExpAll;
        end
        op.rounding_mode = 3'($urandom_range(0, 7));
        op.int_width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(1, 64));
        return op;
    endfunction

    // one start transfer with optional idle gap before it
    task automatic send_op(t_in op);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= op;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rounded_q.push_back(predict_round(op));
    endtask

    // result check on each strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rounded_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h/%b",
                         $realtime, o_item.result_bits, o_item.invalid);
                err_cnt++;
            end else begin
                t_out want;
                want = rounded_q.pop_front();
                if (o_item.result_bits !== want.result_bits) begin
                    $display("%0t result_bits mismatch: expected %h, actual %h",
                             $realtime, want.result_bits, o_item.result_bits);
                    err_cnt++;
                end
                if (o_item.invalid !== want.invalid) begin
                    $display("%0t invalid mismatch: expected %b, actual %b",
                             $realtime, want.invalid, o_item.invalid);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // stimulus
    initial begin
        t_row rows[$];
        t_row row;
        t_in  op;
        int   n;
        int   ph;
        err_cnt  = 0;
        idle_pct = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: zeros, halves, NaN, inf, width extremes, modes
        rows = '{
            '{'{64'h0000000000000000, RM_UP, 7'd1}, 1, '{64'h0, 1'b0}},
            '{'{64'h8000000000000000, RM_DOWN, 7'd1}, 1, '{64'h8000000000000000, 1'b0}},
            '{'{64'h3FE0000000000000, RM_NEAR_EVEN, 7'd8}, 1, '{64'h0, 1'b0}},
            '{'{64'h3FE0000000000000, RM_NEAR_AWAY, 7'd8}, 1, '{PosOne, 1'b0}},
            '{'{64'h3FE0000000000001, RM_NEAR_EVEN, 7'd8}, 1, '{PosOne, 1'b0}},
            '{'{64'hBFE0000000000000, RM_NEAR_AWAY, 7'd1}, 1, '{NegOne, 1'b0}},
            '{'{64'h3FB0000000000000, RM_UP, 7'd8}, 1, '{PosOne, 1'b0}},
            '{'{64'hBFB0000000000000, RM_UP, 7'd8}, 1, '{64'h8000000000000000, 1'b0}},
            '{'{64'hBFB0000000000000, RM_DOWN, 7'd8}, 1, '{NegOne, 1'b0}},
            '{'{64'h3FB0000000000000, RM_ZERO, 7'd8}, 1, '{64'h0, 1'b0}},
            '{'{64'h3FB0000000000000, 3'd7, 7'd8}, 1, '{64'h0, 1'b0}},
            '{'{64'h7FF0000000000000, RM_ZERO, 7'd64}, 1, '{QuietNan, 1'b1}},
            '{'{64'hFFFFFFFFFFFFFFFF, RM_ZERO, 7'd64}, 1, '{QuietNan, 1'b1}},
            '{'{64'h3FF0000000000000, RM_ZERO, 7'd0}, 1, '{QuietNan, 1'b1}},
            '{'{64'h3FF0000000000000, RM_ZERO, 7'd1}, 1, '{QuietNan, 1'b1}},
            '{'{64'hBFF0000000000000, RM_ZERO, 7'd1}, 1, '{NegOne, 1'b0}},
            '{'{64'hC3E0000000000000, RM_ZERO, 7'd64}, 1, '{64'hC3E0000000000000, 1'b0}},
            '{'{64'h43E0000000000000, RM_ZERO, 7'd64}, 1, '{QuietNan, 1'b1}},
            '{'{64'h43E0000000000000, RM_ZERO, 7'd127}, 1, '{64'h43E0000000000000, 1'b0}},
            '{'{64'h4004000000000000, RM_NEAR_EVEN, 7'd8}, 0, '{64'h0, 1'b0}},
            '{'{64'h400C000000000000, RM_NEAR_EVEN, 7'd8}, 0, '{64'h0, 1'b0}},
            '{'{64'hC004000000000000, RM_NEAR_AWAY, 7'd8}, 0, '{64'h0, 1'b0}},
            '{'{64'h4330000000000001, RM_UP, 7'd64}, 0, '{64'h0, 1'b0}},
            '{'{64'h432FFFFFFFFFFFFF, RM_NEAR_EVEN, 7'd64}, 0, '{64'h0, 1'b0}},
            '{'{64'hC05FC00000000000, RM_DOWN, 7'd8}, 0, '{64'h0, 1'b0}}
        };
        foreach (rows[i]) begin
            row = rows[i];
            send_op(row.op);
            // typed-in value stands in for the prediction where given
            if (row.has_exp) rounded_q[rounded_q.size() - 1] = row.exp;
        end

        // random phases, two of them with sender idling
        for (ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 58 : (ph == 2) ? 33 : 0;
            for (n = 0; n < 275; n++) begin
                op = rand_op();
                send_op(op);
            end
            // hold off until every expected transfer has come
            start <= 1'b0;
            @(posedge i_clk);
            while (rounded_q.size() != 0) @(posedge i_clk);
        end

        start <= 1'b0;
        n = 0;
        while (rounded_q.size() != 0 && n < 1000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && rounded_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ double_round_to_int_width_core.f @@
+incdir+src
src/dri_pkg.sv
src/dri_round.sv
src/double_round_to_int_width_core.sv
src/dri_checker.sv
tb/sv/tb_double_round_to_int_width_core.sv
